[rtl/core/bpg_pkg.sv]
package bpg_pkg;

  // sizes
  localparam int MaxElements = 8;
  localparam int PosW        = 3;
  localparam int ValW        = 4;
  localparam int SolW        = 16;

  typedef logic [PosW-1:0]        pos_t;
  typedef logic [ValW-1:0]        val_t;
  typedef logic [SolW-1:0]        sol_t;
  typedef logic [MaxElements-1:0] mask_t;

  // length after reset
  localparam val_t LenReset = 4'd4;

  // request to the free-value finder
  typedef struct packed {
    val_t  cur_val;
    val_t  n_eff;
    mask_t used;
  } free_req_t;

  // answer of the free-value finder
  typedef struct packed {
    logic found;
    val_t value;
  } free_res_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic val_t clamp_len(input val_t raw);
    val_t n;
    n = raw;
    if (raw == val_t'(0)) n = val_t'(1);
    if (raw > val_t'(MaxElements)) n = val_t'(MaxElements);
    return n;
  endfunction

  // one-hot mask for value v (bit v-1); zero gives an empty mask
  function automatic mask_t val_bit(input val_t v);
    mask_t m;
    for (int i = 0; i < MaxElements; i++) begin
      m[i] = (v == val_t'(i + 1));
    end
    return m;
  endfunction

endpackage

[rtl/core/bpg_next_free.sv]
module bpg_next_free (
  input  bpg_pkg::free_req_t req,
  output bpg_pkg::free_res_t res
);
  import bpg_pkg::*;

  // smallest value above cur_val, at most n, not held by an earlier position
  always_comb begin
    res = '0;
    for (int i = MaxElements - 1; i >= 0; i--) begin
      if ((val_t'(i + 1) > req.cur_val) && (val_t'(i + 1) <= req.n_eff) && !req.used[i]) begin
        res.found = 1'b1;
        res.value = val_t'(i + 1);
      end
    end
  end

endmodule

[rtl/core/backtracking_permutation_generator.sv]
// Search: a forward step passes through the search state, a backtrack step through the
//   search and pop states; then the n results stream one per cycle from a registered read.
// Finished listing: a request gets its one result in the next cycle, no busy time.
// Requests: a new permutation request is taken only in idle, once busy has dropped after
//   the previous request's search and serial readout; results cannot be stalled.
// Reset (rst_n low, synchronous): length 4, listing restarted, no results pending.
module backtracking_permutation_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_restart,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  bpg_pkg::val_t      cfg_perm_length,
  output logic               out_valid,
  output bpg_pkg::pos_t      out_position,
  output bpg_pkg::val_t      out_element_value,
  output bpg_pkg::sol_t      out_solution_number,
  output logic               out_last_of_run,
  output logic               out_exhausted
);
  import bpg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_POP,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  pos_t   level_r, level_nxt;
  val_t   cur_val_r, cur_val_nxt;
  mask_t  used_r, used_nxt;
  sol_t   sol_r, sol_nxt;
  logic   fin_r, fin_nxt;
  val_t   len_r, len_nxt;
  pos_t   rd_idx_r, rd_idx_nxt;
  logic   pend_r, pend_nxt;
  pos_t   pidx_r, pidx_nxt;
  logic   plast_r, plast_nxt;
  logic   exh_r, exh_nxt;

  // position memory
  val_t   pos_mem [MaxElements];
  val_t   rdata_r;
  logic   mem_we, mem_re;
  pos_t   mem_waddr, mem_raddr;
  val_t   mem_wdata;

  val_t      n_eff, n_m1;
  pos_t      last_lvl;
  logic      fin_now;
  free_req_t fr_req;
  free_res_t fr_res;

  assign n_eff    = clamp_len(len_r);
  assign n_m1     = n_eff - val_t'(1);
  assign last_lvl = n_m1[PosW-1:0];

  assign fr_req.cur_val = cur_val_r;
  assign fr_req.n_eff   = n_eff;
  assign fr_req.used    = used_r;

  bpg_next_free u_next_free (
    .req (fr_req),
    .res (fr_res)
  );

  // next-state logic
  always_comb begin
    state_nxt   = state_r;
    level_nxt   = level_r;
    cur_val_nxt = cur_val_r;
    used_nxt    = used_r;
    sol_nxt     = sol_r;
    fin_nxt     = fin_r;
    len_nxt     = len_r;
    rd_idx_nxt  = rd_idx_r;
    pend_nxt    = 1'b0;
    pidx_nxt    = pidx_r;
    plast_nxt   = plast_r;
    exh_nxt     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = level_r;
    mem_wdata   = fr_res.value;
    mem_re      = 1'b0;
    mem_raddr   = rd_idx_r;
    fin_now     = fin_r;

    unique case (state_r)
      ST_IDLE: begin
        // a length write restarts the listing
        if (cfg_valid && cfg_ready) begin
          len_nxt     = cfg_perm_length;
          level_nxt   = '0;
          cur_val_nxt = '0;
          used_nxt    = '0;
          sol_nxt     = '0;
          fin_nxt     = 1'b0;
          fin_now     = 1'b0;
        end
        if (start) begin
          if (in_restart) begin
            level_nxt   = '0;
            cur_val_nxt = '0;
            used_nxt    = '0;
            sol_nxt     = '0;
            fin_nxt     = 1'b0;
            state_nxt   = ST_SEARCH;
          end else if (fin_now) begin
            exh_nxt = 1'b1;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (fr_res.found) begin
          mem_we = 1'b1;
          if (level_r == last_lvl) begin
            // full permutation: stream it out
            cur_val_nxt = fr_res.value;
            sol_nxt     = sol_r + sol_t'(1);
            rd_idx_nxt  = '0;
            state_nxt   = ST_EMIT;
          end else begin
            used_nxt    = used_r | val_bit(fr_res.value);
            level_nxt   = level_r + pos_t'(1);
            cur_val_nxt = '0;
          end
        end else if (level_r == '0) begin
          fin_nxt   = 1'b1;
          exh_nxt   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          // backtrack: fetch the value one level down
          level_nxt = level_r - pos_t'(1);
          mem_re    = 1'b1;
          mem_raddr = level_r - pos_t'(1);
          state_nxt = ST_POP;
        end
      end

      ST_POP: begin
        cur_val_nxt = rdata_r;
        used_nxt    = used_r & ~val_bit(rdata_r);
        state_nxt   = ST_SEARCH;
      end

      ST_EMIT: begin
        mem_re     = 1'b1;
        mem_raddr  = rd_idx_r;
        pend_nxt   = 1'b1;
        pidx_nxt   = rd_idx_r;
        plast_nxt  = (rd_idx_r == last_lvl);
        rd_idx_nxt = rd_idx_r + pos_t'(1);
        if (rd_idx_r == last_lvl) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      level_r   <= '0;
      cur_val_r <= '0;
      used_r    <= '0;
      sol_r     <= '0;
      fin_r     <= 1'b0;
      len_r     <= LenReset;
      rd_idx_r  <= '0;
      pend_r    <= 1'b0;
      exh_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      level_r   <= level_nxt;
      cur_val_r <= cur_val_nxt;
      used_r    <= used_nxt;
      sol_r     <= sol_nxt;
      fin_r     <= fin_nxt;
      len_r     <= len_nxt;
      rd_idx_r  <= rd_idx_nxt;
      pend_r    <= pend_nxt;
      exh_r     <= exh_nxt;
    end
    pidx_r  <= pidx_nxt;
    plast_r <= plast_nxt;
  end

  // position memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) pos_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= pos_mem[mem_raddr];
  end

  // handshake and result ports
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  assign out_valid           = pend_r | exh_r;
  assign out_position        = exh_r ? '0 : pidx_r;
  assign out_element_value   = exh_r ? '0 : rdata_r;
  assign out_solution_number = exh_r ? '0 : sol_r;
  assign out_last_of_run     = exh_r | plast_r;
  assign out_exhausted       = exh_r;

endmodule

[rtl/core/bpg_checker.sv]
module bpg_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input bpg_pkg::pos_t out_position,
  input bpg_pkg::val_t out_element_value,
  input bpg_pkg::sol_t out_solution_number,
  input logic          out_last_of_run,
  input logic          out_exhausted
);
  import bpg_pkg::*;

  // an exhausted result is a lone, all-zero, final result
  a_exh_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exhausted |-> out_last_of_run && out_position == '0 &&
      out_element_value == '0 && out_solution_number == '0)
    else $error("exhausted result malformed");

  // a permutation result carries a real value and a nonzero number
  a_perm_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_exhausted |-> out_element_value != '0 && out_solution_number != '0)
    else $error("permutation result carries zero");

  // a run streams without gaps, positions counting up, same number
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |=> out_valid && !out_exhausted &&
      out_position == pos_t'($past(out_position) + pos_t'(1)) &&
      out_solution_number == $past(out_solution_number))
    else $error("run broken");

  // an accepted request either keeps the block busy or answers at once
  a_req_answer: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && start && !busy |=> busy || (out_valid && out_exhausted))
    else $error("request dropped");

endmodule

bind backtracking_permutation_generator bpg_checker u_bpg_checker (.*);
